// ----- rtl/core/sts_pkg.sv -----
// Shared types, codes and the keyword table of the SQL token scanner.
// Used by every module of the scanner; depends on nothing.
package sts_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 24;
	localparam int KEYWORD_MAX_DEF = 8;
	localparam int KW_COUNT        = 40;

	// Scanner modes between bytes
	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_WORD, M_NUM, M_NUMDOT, M_FRAC, M_STR, M_STRBS,
		M_STRQ, M_MINUS, M_BANG, M_LT, M_GT
	} mode_e;

	// Token type codes below the keyword range
	typedef enum logic [5:0] {
		T_EOF, T_ILLEGAL, T_IDENT, T_INT, T_FLOAT, T_STRING, T_EQ, T_NE,
		T_LT, T_LE, T_GT, T_GE, T_PLUS, T_MINUS, T_STAR, T_SLASH, T_COMMA,
		T_SEMI, T_LPAREN, T_RPAREN, T_DOT
	} tok_e;

	// One result item
	typedef struct packed {
		logic [5:0]  ttype;
		logic [15:0] line;
		logic [15:0] col;
		logic [23:0] off;
		logic [15:0] len;
		logic        last;
	} tok_t;

	// Keyword text, right-justified, first letter in the highest used byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("CREATE"), 64'("TABLE"), 64'("DROP"), 64'("INSERT"),
		64'("INTO"), 64'("VALUES"), 64'("SELECT"), 64'("FROM"),
		64'("WHERE"), 64'("ORDER"), 64'("BY"), 64'("ASC"),
		64'("DESC"), 64'("LIMIT"), 64'("UPDATE"), 64'("SET"),
		64'("DELETE"), 64'("JOIN"), 64'("INNER"), 64'("LEFT"),
		64'("ON"), 64'("GROUP"), 64'("INDEX"), 64'("BEGIN"),
		64'("COMMIT"), 64'("ROLLBACK"), 64'("INT"), 64'("INTEGER"),
		64'("BIGINT"), 64'("DOUBLE"), 64'("BOOLEAN"), 64'("BOOL"),
		64'("VARCHAR"), 64'("AND"), 64'("OR"), 64'("NOT"),
		64'("TRUE"), 64'("FALSE"), 64'("NULL"), 64'("EXPLAIN")
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd5, 4'd4, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4,
		4'd5, 4'd5, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd3,
		4'd6, 4'd4, 4'd5, 4'd4, 4'd2, 4'd5, 4'd5, 4'd5,
		4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4,
		4'd7, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5, 4'd4, 4'd7
	};

	localparam logic [5:0] KW_CODE [KW_COUNT] = '{
		6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
		6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
		6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44,
		6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd49, 6'd50, 6'd50,
		6'd51, 6'd52, 6'd53, 6'd54, 6'd55, 6'd56, 6'd57, 6'd58
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// Parallel compare of the word buffer against the whole table; 0 = no match
	function automatic logic [5:0] kw_lookup(input logic [7:0][7:0] kb, input logic [15:0] len);
		logic [5:0] code;
		logic       hit;
		code = '0;
		for (int e = KW_COUNT - 1; e >= 0; e--) begin
			hit = (len == 16'(KW_LEN[e]));
			for (int i = 0; i < 8; i++) begin
				if (i < int'(KW_LEN[e]))
					hit = hit & (kb[i] == KW_TEXT[e][8 * (int'(KW_LEN[e]) - 1 - i) +: 8]);
			end
			if (hit)
				code = KW_CODE[e];
		end
		return code;
	endfunction

endpackage

// ----- rtl/core/sts_in_if.sv -----
// Byte channel of the SQL token scanner: valid/ready plus command and byte.
// Depends on nothing.
interface sts_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] char_in;

	modport source (output valid, cmd, char_in, input ready);
	modport sink (input valid, cmd, char_in, output ready);
endinterface

// ----- rtl/core/sts_out_if.sv -----
// Token channel of the SQL token scanner: valid/ready plus token fields.
// Depends on nothing.
interface sts_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_type;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [23:0] start_offset;
	logic [15:0] source_length;
	logic        last_of_run;

	modport source (output valid, token_type, token_line, token_column, start_offset,
		source_length, last_of_run, input ready);
	modport sink (input valid, token_type, token_line, token_column, start_offset,
		source_length, last_of_run, output ready);
endinterface

// ----- rtl/core/sts_lexer.sv -----
// Scanner state and the per-byte next-state logic; yields up to three tokens per item.
// Depends on sts_pkg.
module sts_lexer #(
	parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = sts_pkg::COLUMN_BITS_DEF,
	parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
	parameter int KEYWORD_MAX = sts_pkg::KEYWORD_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               cmd,
	input  logic [7:0]         char_in,
	output logic [1:0]         res_n,
	output sts_pkg::tok_t      res [3]
);

	localparam int KIDX = (KEYWORD_MAX > 1) ? $clog2(KEYWORD_MAX) : 1;

	sts_pkg::mode_e         mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d, tbc_q, tbc_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, tb_q, tb_d;
	logic [15:0]            span_q, span_d;
	logic                   wtl_q, wtl_d;
	logic [7:0]             kb_q [KEYWORD_MAX];
	logic [7:0]             kb_d [KEYWORD_MAX];
	logic [7:0][7:0]        kb8;
	logic [5:0]             kw_code, word_type;
	logic                   pass;
	logic [7:0]             c;

	function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
		return v + 1'b1;
	endfunction

	function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] span_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic sts_pkg::tok_t mk(input logic [5:0] t, input logic [LINE_BITS-1:0] ln,
		input logic [COLUMN_BITS-1:0] cl, input logic [OFFSET_BITS-1:0] of,
		input logic [15:0] len);
		sts_pkg::tok_t r;
		r.ttype = t;
		r.line  = 16'(ln);
		r.col   = 16'(cl);
		r.off   = 24'(of);
		r.len   = len;
		r.last  = 1'b0;
		return r;
	endfunction

	// Keyword match on the word held so far
	always_comb begin
		for (int i = 0; i < 8; i++)
			kb8[i] = kb_q[i];
	end
	assign kw_code   = sts_pkg::kw_lookup(kb8, span_q);
	assign word_type = (wtl_q || kw_code == 6'd0) ? 6'(sts_pkg::T_IDENT) : kw_code;
	assign c         = char_in;

	// Next state and tokens for one item
	always_comb begin
		mode_d = mode_q; line_d = line_q; col_d = col_q; off_d = off_q;
		tb_d = tb_q; tbc_d = tbc_q; span_d = span_q; wtl_d = wtl_q; kb_d = kb_q;
		res_n = 2'd0;
		res = '{default: '0};
		pass = 1'b0;
		if (fire) begin
			if (cmd) begin
				// end of source: flush the open token, then end-of-file
				unique case (mode_q)
					sts_pkg::M_WORD: begin
						res[res_n] = mk(word_type, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_NUM: begin
						res[res_n] = mk(sts_pkg::T_INT, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_NUMDOT: begin
						res[res_n] = mk(sts_pkg::T_INT, line_d, tbc_d, tb_d, span_d); res_n++;
						tb_d = off_d; tbc_d = col_d; span_d = 16'd0; wtl_d = 1'b0;
						off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
						res[res_n] = mk(sts_pkg::T_DOT, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_FRAC: begin
						res[res_n] = mk(sts_pkg::T_FLOAT, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_STR, sts_pkg::M_STRBS, sts_pkg::M_BANG: begin
						res[res_n] = mk(sts_pkg::T_ILLEGAL, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_STRQ: begin
						res[res_n] = mk(sts_pkg::T_STRING, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_MINUS: begin
						res[res_n] = mk(sts_pkg::T_MINUS, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_LT: begin
						res[res_n] = mk(sts_pkg::T_LT, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					sts_pkg::M_GT: begin
						res[res_n] = mk(sts_pkg::T_GT, line_d, tbc_d, tb_d, span_d); res_n++;
					end
					default: ;
				endcase
				res[res_n] = mk(sts_pkg::T_EOF, line_d, col_d, off_d, 16'd0); res_n++;
				mode_d = sts_pkg::M_IDLE; line_d = LINE_BITS'(1); col_d = COLUMN_BITS'(1);
				off_d = '0; tb_d = '0; tbc_d = COLUMN_BITS'(1); span_d = 16'd0; wtl_d = 1'b0;
			end else begin
				// byte in the current mode
				unique case (mode_q)
					sts_pkg::M_COMMENT: begin
						if (c == 8'h0A) begin
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end else begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
						end
					end
					sts_pkg::M_WORD: begin
						if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c) || c == "_") begin
							if (span_q < 16'(KEYWORD_MAX))
								kb_d[span_q[KIDX-1:0]] = sts_pkg::to_upper(c);
							else
								wtl_d = 1'b1;
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
						end else begin
							res[res_n] = mk(word_type, line_d, tbc_d, tb_d, span_d); res_n++;
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end
					end
					sts_pkg::M_NUM: begin
						if (sts_pkg::is_digit(c)) begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
						end else if (c == ".") begin
							mode_d = sts_pkg::M_NUMDOT;
						end else begin
							res[res_n] = mk(sts_pkg::T_INT, line_d, tbc_d, tb_d, span_d); res_n++;
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end
					end
					sts_pkg::M_NUMDOT: begin
						if (sts_pkg::is_digit(c)) begin
							// dot and digit both join the number
							off_d = off_inc(off_inc(off_d));
							col_d = col_inc(col_inc(col_d));
							span_d = span_inc(span_inc(span_d));
							mode_d = sts_pkg::M_FRAC;
						end else begin
							res[res_n] = mk(sts_pkg::T_INT, line_d, tbc_d, tb_d, span_d); res_n++;
							tb_d = off_d; tbc_d = col_d; span_d = 16'd0; wtl_d = 1'b0;
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
							res[res_n] = mk(sts_pkg::T_DOT, line_d, tbc_d, tb_d, span_d); res_n++;
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end
					end
					sts_pkg::M_FRAC: begin
						if (sts_pkg::is_digit(c)) begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
						end else begin
							res[res_n] = mk(sts_pkg::T_FLOAT, line_d, tbc_d, tb_d, span_d); res_n++;
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end
					end
					sts_pkg::M_STR, sts_pkg::M_STRBS: begin
						// backslash escapes only a following quote
						mode_d = sts_pkg::M_STR;
						if (mode_q == sts_pkg::M_STR && c == "'")
							mode_d = sts_pkg::M_STRQ;
						else if (c == "\\")
							mode_d = sts_pkg::M_STRBS;
						off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
					end
					sts_pkg::M_STRQ: begin
						if (c == "'") begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
							mode_d = sts_pkg::M_STR;
						end else begin
							res[res_n] = mk(sts_pkg::T_STRING, line_d, tbc_d, tb_d, span_d); res_n++;
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end
					end
					sts_pkg::M_MINUS: begin
						if (c == "-") begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
							mode_d = sts_pkg::M_COMMENT;
						end else begin
							res[res_n] = mk(sts_pkg::T_MINUS, line_d, tbc_d, tb_d, span_d); res_n++;
							mode_d = sts_pkg::M_IDLE; pass = 1'b1;
						end
					end
					sts_pkg::M_BANG: begin
						mode_d = sts_pkg::M_IDLE;
						if (c == "=") begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
							res[res_n] = mk(sts_pkg::T_NE, line_d, tbc_d, tb_d, span_d); res_n++;
						end else begin
							res[res_n] = mk(sts_pkg::T_ILLEGAL, line_d, tbc_d, tb_d, span_d); res_n++;
							pass = 1'b1;
						end
					end
					sts_pkg::M_LT: begin
						mode_d = sts_pkg::M_IDLE;
						if (c == "=" || c == ">") begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
							res[res_n] = mk((c == "=") ? 6'(sts_pkg::T_LE) : 6'(sts_pkg::T_NE),
								line_d, tbc_d, tb_d, span_d);
							res_n++;
						end else begin
							res[res_n] = mk(sts_pkg::T_LT, line_d, tbc_d, tb_d, span_d); res_n++;
							pass = 1'b1;
						end
					end
					sts_pkg::M_GT: begin
						mode_d = sts_pkg::M_IDLE;
						if (c == "=") begin
							off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
							res[res_n] = mk(sts_pkg::T_GE, line_d, tbc_d, tb_d, span_d); res_n++;
						end else begin
							res[res_n] = mk(sts_pkg::T_GT, line_d, tbc_d, tb_d, span_d); res_n++;
							pass = 1'b1;
						end
					end
					default: begin
						mode_d = sts_pkg::M_IDLE; pass = 1'b1;
					end
				endcase

				// byte seen between tokens
				if (pass) begin
					if (c == " " || c == 8'h09 || c == 8'h0D) begin
						off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
					end else if (c == 8'h0A) begin
						off_d = off_inc(off_d); line_d = line_inc(line_d); col_d = COLUMN_BITS'(1);
					end else begin
						tb_d = off_d; tbc_d = col_d; span_d = 16'd0; wtl_d = 1'b0;
						off_d = off_inc(off_d); col_d = col_inc(col_d); span_d = span_inc(span_d);
						if (sts_pkg::is_alpha(c) || c == "_") begin
							kb_d[0] = sts_pkg::to_upper(c);
							mode_d = sts_pkg::M_WORD;
						end else if (sts_pkg::is_digit(c)) begin
							mode_d = sts_pkg::M_NUM;
						end else begin
							unique case (c)
								"'": mode_d = sts_pkg::M_STR;
								"-": mode_d = sts_pkg::M_MINUS;
								"!": mode_d = sts_pkg::M_BANG;
								"<": mode_d = sts_pkg::M_LT;
								">": mode_d = sts_pkg::M_GT;
								"=": begin
									res[res_n] = mk(sts_pkg::T_EQ, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								"+": begin
									res[res_n] = mk(sts_pkg::T_PLUS, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								"*": begin
									res[res_n] = mk(sts_pkg::T_STAR, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								"/": begin
									res[res_n] = mk(sts_pkg::T_SLASH, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								",": begin
									res[res_n] = mk(sts_pkg::T_COMMA, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								";": begin
									res[res_n] = mk(sts_pkg::T_SEMI, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								"(": begin
									res[res_n] = mk(sts_pkg::T_LPAREN, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								")": begin
									res[res_n] = mk(sts_pkg::T_RPAREN, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								".": begin
									res[res_n] = mk(sts_pkg::T_DOT, line_d, tbc_d, tb_d, span_d); res_n++;
								end
								default: begin
									res[res_n] = mk(sts_pkg::T_ILLEGAL, line_d, tbc_d, tb_d, span_d);
									res_n++;
								end
							endcase
						end
					end
				end
			end
			// mark the final token of this item
			if (res_n != 2'd0)
				res[res_n - 2'd1].last = 1'b1;
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sts_pkg::M_IDLE;
			line_q <= LINE_BITS'(1);
			col_q  <= COLUMN_BITS'(1);
			off_q  <= '0;
			tb_q   <= '0;
			tbc_q  <= COLUMN_BITS'(1);
			span_q <= 16'd0;
			wtl_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			off_q  <= off_d;
			tb_q   <= tb_d;
			tbc_q  <= tbc_d;
			span_q <= span_d;
			wtl_q  <= wtl_d;
		end
	end

	// Word buffer: only bytes written in the current word are ever compared
	always_ff @(posedge clk) begin
		kb_q <= kb_d;
	end

endmodule

// ----- rtl/core/sts_outq.sv -----
// Three-entry token buffer that hands out the tokens of one item in order.
// Depends on sts_pkg and sts_out_if.
module sts_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [1:0]        n,
	input  sts_pkg::tok_t     toks [3],
	output logic              can_load,
	sts_out_if.source         tokens
);

	sts_pkg::tok_t q_q [3];
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop      = tokens.valid && tokens.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	// Head entry drives the channel
	assign tokens.valid         = (cnt_q != 2'd0);
	assign tokens.token_type    = q_q[0].ttype;
	assign tokens.token_line    = q_q[0].line;
	assign tokens.token_column  = q_q[0].col;
	assign tokens.start_offset  = q_q[0].off;
	assign tokens.source_length = q_q[0].len;
	assign tokens.last_of_run   = q_q[0].last;

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entries: load all at once, shift on each take
	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= toks;
		end else if (pop) begin
			q_q[0] <= q_q[1];
			q_q[1] <= q_q[2];
		end
	end

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cnt_q == $past(n))
		else $error("buffer count differs from tokens loaded");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("buffer count not reduced on take");

	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> q_q[0].last)
		else $error("final buffered token lacks last mark");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > 2'd1) |-> !load)
		else $error("load while earlier tokens pending");

endmodule

// ----- rtl/core/sql_token_scanner.sv -----
// SQL token scanner: how to use it.
// Channel text (sink) takes one item per handshake: cmd 0 carries a source byte in
// char_in, cmd 1 marks the end of the source. Channel tokens (source) gives result
// items: type, start line and column, start offset, length and last_of_run, which
// is high on the final token caused by one item.
// A token that could still grow is reported when the byte after it arrives, or at
// the end item, which also gives the end-of-file token and returns the scanner to
// line 1, column 1, offset 0. Other tokens are reported on their own last byte.
// Path: an item taken on text waits in the input register until the token buffer
// can load, is then scanned, and its tokens are registered into the token buffer,
// whose head is on tokens (input register, then the token buffer). Throughput: one item
// per cycle while each item causes at most one token and tokens takes every token;
// an item causing more tokens holds back the next one until the single token port
// has drained the three-entry buffer down to its last token.
// When tokens is stalled, one item waits in the input register and text
// backpressures once that is full; nothing is dropped.
// Reset (arst_n low) empties both registers and puts the scanner between tokens.
// Depends on sts_pkg, sts_in_if, sts_out_if, sts_lexer and sts_outq.
module sql_token_scanner #(
	parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = sts_pkg::COLUMN_BITS_DEF,
	parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
	parameter int KEYWORD_MAX = sts_pkg::KEYWORD_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sts_in_if.sink    text,
	sts_out_if.source tokens
);

	logic          valid_s1;
	logic          cmd_s1;
	logic [7:0]    char_s1;
	logic          can_load;
	logic          fire;
	logic [1:0]    res_n;
	sts_pkg::tok_t res [3];

	assign fire       = valid_s1 && can_load;
	assign text.ready = !valid_s1 || can_load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			cmd_s1  <= text.cmd;
			char_s1 <= text.char_in;
		end
	end

	sts_lexer #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.OFFSET_BITS (OFFSET_BITS),
		.KEYWORD_MAX (KEYWORD_MAX)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.cmd     (cmd_s1),
		.char_in (char_s1),
		.res_n   (res_n),
		.res     (res)
	);

	sts_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.n        (res_n),
		.toks     (res),
		.can_load (can_load),
		.tokens   (tokens)
	);

endmodule

// ----- bench/sts_checker.sv -----
`timescale 1ns / 1ps
// Token checker for the SQL token scanner: watches both channels, predicts tokens.
// Depends on sts_pkg, sts_in_if and sts_out_if.
module sts_checker (
	input  logic      clk,
	input  logic      arst_n,
	sts_in_if         text,
	sts_out_if        tokens,
	output int        errors,
	output int        pending
);

	// Scanner state as predicted
	sts_pkg::mode_e mode;
	logic [15:0] line_no;
	logic [15:0] col_no;
	logic [23:0] offset;
	logic [23:0] tok_off;
	logic [15:0] tok_col;
	logic [15:0] tok_span;
	logic [7:0]  word_buf [8];
	logic        word_long;

	sts_pkg::tok_t step_toks [$];
	sts_pkg::tok_t want_tokens [$];

	assign pending = want_tokens.size();

	function automatic logic alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task clear_state();
		mode = sts_pkg::M_IDLE;
		line_no = 16'd1;
		col_no = 16'd1;
		offset = '0;
		tok_off = '0;
		tok_col = 16'd1;
		tok_span = '0;
		for (int i = 0; i < 8; i++) word_buf[i] = '0;
		word_long = 1'b0;
	endtask

	task advance();
		offset = offset + 24'd1;
		if (col_no != 16'hFFFF) col_no = col_no + 16'd1;
		if (tok_span != 16'hFFFF) tok_span = tok_span + 16'd1;
	endtask

	task open_token();
		tok_off = offset;
		tok_col = col_no;
		tok_span = '0;
		word_long = 1'b0;
	endtask

	task push_tok(input logic [5:0] tt, input logic [15:0] c, input logic [23:0] o,
			input logic [15:0] n);
		sts_pkg::tok_t t;
		if (step_toks.size() >= 3) return;
		t.ttype = tt;
		t.line = line_no;
		t.col = c;
		t.off = o;
		t.len = n;
		t.last = 1'b0;
		step_toks = {step_toks, t};
	endtask

	task push_current(input logic [5:0] tt);
		push_tok(tt, tok_col, tok_off, tok_span);
	endtask

	// First table entry of matching length and text wins
	task push_word();
		logic       hit;
		logic [5:0] code;
		code = sts_pkg::T_IDENT;
		if (!word_long) begin
			for (int e = sts_pkg::KW_COUNT - 1; e >= 0; e--) begin
				hit = (tok_span == 16'(sts_pkg::KW_LEN[e]));
				for (int i = 0; i < 8; i++)
					if (hit && i < int'(sts_pkg::KW_LEN[e]))
						hit = word_buf[i] ==
							sts_pkg::KW_TEXT[e][8 * (int'(sts_pkg::KW_LEN[e]) - 1 - i) +: 8];
				if (hit) code = sts_pkg::KW_CODE[e];
			end
		end
		push_current(code);
	endtask

	task push_lone_dot();
		open_token();
		advance();
		push_current(sts_pkg::T_DOT);
	endtask

	function automatic logic [7:0] upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// Byte seen between tokens
	task idle_byte(input logic [7:0] c);
		if (c == " " || c == 8'h09 || c == 8'h0D) begin
			advance();
			return;
		end
		if (c == 8'h0A) begin
			offset = offset + 24'd1;
			if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
			col_no = 16'd1;
			return;
		end
		open_token();
		if (alpha(c) || c == "_") begin
			word_buf[0] = upper(c);
			advance();
			mode = sts_pkg::M_WORD;
			return;
		end
		advance();
		if (digit(c)) mode = sts_pkg::M_NUM;
		else case (c)
			"'": mode = sts_pkg::M_STR;
			"-": mode = sts_pkg::M_MINUS;
			"!": mode = sts_pkg::M_BANG;
			"<": mode = sts_pkg::M_LT;
			">": mode = sts_pkg::M_GT;
			"=": push_current(sts_pkg::T_EQ);
			"+": push_current(sts_pkg::T_PLUS);
			"*": push_current(sts_pkg::T_STAR);
			"/": push_current(sts_pkg::T_SLASH);
			",": push_current(sts_pkg::T_COMMA);
			";": push_current(sts_pkg::T_SEMI);
			"(": push_current(sts_pkg::T_LPAREN);
			")": push_current(sts_pkg::T_RPAREN);
			".": push_current(sts_pkg::T_DOT);
			default: push_current(sts_pkg::T_ILLEGAL);
		endcase
	endtask

	// One source byte
	task lex_byte(input logic [7:0] c);
		logic handed;
		handed = 1'b1;
		case (mode)
			sts_pkg::M_COMMENT: begin
				if (c != 8'h0A) begin
					advance();
					handed = 1'b0;
				end
			end
			sts_pkg::M_WORD: begin
				if (alpha(c) || digit(c) || c == "_") begin
					if (tok_span < 16'd8) word_buf[tok_span[2:0]] = upper(c);
					else word_long = 1'b1;
					advance();
					handed = 1'b0;
				end else push_word();
			end
			sts_pkg::M_NUM: begin
				if (digit(c)) begin
					advance();
					handed = 1'b0;
				end else if (c == ".") begin
					mode = sts_pkg::M_NUMDOT;
					handed = 1'b0;
				end else push_current(sts_pkg::T_INT);
			end
			sts_pkg::M_NUMDOT: begin
				if (digit(c)) begin
					advance();
					advance();
					mode = sts_pkg::M_FRAC;
					handed = 1'b0;
				end else begin
					push_current(sts_pkg::T_INT);
					push_lone_dot();
				end
			end
			sts_pkg::M_FRAC: begin
				if (digit(c)) begin
					advance();
					handed = 1'b0;
				end else push_current(sts_pkg::T_FLOAT);
			end
			sts_pkg::M_STR, sts_pkg::M_STRBS: begin
				handed = 1'b0;
				if (mode == sts_pkg::M_STRBS && c == "'") mode = sts_pkg::M_STR;
				else if (c == "'") mode = sts_pkg::M_STRQ;
				else if (c == "\\") mode = sts_pkg::M_STRBS;
				else mode = sts_pkg::M_STR;
				advance();
			end
			sts_pkg::M_STRQ: begin
				if (c == "'") begin
					advance();
					mode = sts_pkg::M_STR;
					handed = 1'b0;
				end else push_current(sts_pkg::T_STRING);
			end
			sts_pkg::M_MINUS: begin
				if (c == "-") begin
					advance();
					mode = sts_pkg::M_COMMENT;
					handed = 1'b0;
				end else push_current(sts_pkg::T_MINUS);
			end
			sts_pkg::M_BANG: begin
				if (c == "=") begin
					advance();
					push_current(sts_pkg::T_NE);
					mode = sts_pkg::M_IDLE;
					handed = 1'b0;
				end else push_current(sts_pkg::T_ILLEGAL);
			end
			sts_pkg::M_LT: begin
				if (c == "=" || c == ">") begin
					advance();
					push_current(c == "=" ? sts_pkg::T_LE : sts_pkg::T_NE);
					mode = sts_pkg::M_IDLE;
					handed = 1'b0;
				end else push_current(sts_pkg::T_LT);
			end
			sts_pkg::M_GT: begin
				if (c == "=") begin
					advance();
					push_current(sts_pkg::T_GE);
					mode = sts_pkg::M_IDLE;
					handed = 1'b0;
				end else push_current(sts_pkg::T_GT);
			end
			default: ;
		endcase
		if (handed) begin
			mode = sts_pkg::M_IDLE;
			idle_byte(c);
		end
	endtask

	// End item: flush the open token, then end of file
	task lex_end();
		case (mode)
			sts_pkg::M_WORD: push_word();
			sts_pkg::M_NUM: push_current(sts_pkg::T_INT);
			sts_pkg::M_NUMDOT: begin
				push_current(sts_pkg::T_INT);
				push_lone_dot();
			end
			sts_pkg::M_FRAC: push_current(sts_pkg::T_FLOAT);
			sts_pkg::M_STR, sts_pkg::M_STRBS, sts_pkg::M_BANG: push_current(sts_pkg::T_ILLEGAL);
			sts_pkg::M_STRQ: push_current(sts_pkg::T_STRING);
			sts_pkg::M_MINUS: push_current(sts_pkg::T_MINUS);
			sts_pkg::M_LT: push_current(sts_pkg::T_LT);
			sts_pkg::M_GT: push_current(sts_pkg::T_GT);
			default: ;
		endcase
		push_tok(sts_pkg::T_EOF, col_no, offset, 16'd0);
		clear_state();
	endtask

	always @(posedge clk or negedge arst_n) begin
		sts_pkg::tok_t w;
		if (!arst_n) begin
			clear_state();
			want_tokens.delete();
			errors <= 0;
		end else begin
			// predict tokens of an accepted item
			if (text.valid && text.ready) begin
				step_toks.delete();
				if (text.cmd) lex_end();
				else lex_byte(text.char_in);
				if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
				want_tokens = {want_tokens, step_toks};
			end
			// compare an accepted token
			if (tokens.valid && tokens.ready) begin
				if (want_tokens.size() == 0) begin
					$error("token with none expected: type %0d", tokens.token_type);
					errors <= errors + 1;
				end else begin
					w = want_tokens.pop_front();
					if (tokens.token_type !== w.ttype ||
							tokens.token_line !== w.line ||
							tokens.token_column !== w.col ||
							tokens.start_offset !== w.off ||
							tokens.source_length !== w.len ||
							tokens.last_of_run !== w.last)
						errors <= errors + 1;
					if (tokens.token_type !== w.ttype)
						$error("token_type exp %0d got %0d", w.ttype, tokens.token_type);
					if (tokens.token_line !== w.line)
						$error("token_line exp %0d got %0d", w.line, tokens.token_line);
					if (tokens.token_column !== w.col)
						$error("token_column exp %0d got %0d", w.col, tokens.token_column);
					if (tokens.start_offset !== w.off)
						$error("start_offset exp %0d got %0d", w.off, tokens.start_offset);
					if (tokens.source_length !== w.len)
						$error("source_length exp %0d got %0d", w.len, tokens.source_length);
					if (tokens.last_of_run !== w.last)
						$error("last_of_run exp %0d got %0d", w.last, tokens.last_of_run);
				end
			end
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Top of the SQL token scanner bench: clock, reset, byte stimulus and verdict.
// Depends on sts_pkg, sts_in_if, sts_out_if, sql_token_scanner and sts_checker.
module tb;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cyc;
	int   hold_left;
	int   rx_mode;

	sts_in_if  text_ch ();
	sts_out_if tok_ch ();

	sql_token_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (tok_ch)
	);

	sts_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.tokens  (tok_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: changing stall patterns, and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc <= 0;
			hold_left <= 0;
			rx_mode <= 0;
			tok_ch.ready <= 1'b0;
		end else begin
			cyc <= cyc + 1;
			if (cyc == 300) hold_left <= 80;
			else if (hold_left > 0) hold_left <= hold_left - 1;
			if (cyc % 32 == 0) rx_mode <= $urandom_range(0, 2);
			if (hold_left > 0 || cyc == 300) tok_ch.ready <= 1'b0;
			else case (rx_mode)
				0: tok_ch.ready <= 1'b1;
				1: tok_ch.ready <= 1'($urandom_range(0, 1));
				default: tok_ch.ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// Offer one item and hold it until taken; random gaps between bursts
	task send(input logic c, input logic [7:0] b);
		if ($urandom_range(0, 7) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.cmd <= c;
		text_ch.char_in <= b;
		do @(negedge clk); while (!text_ch.ready);
		@(posedge clk);
	endtask

	task send_text(input string s);
		foreach (s[i]) send(1'b0, s[i]);
	endtask

	task send_end();
		send(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// Random well-formed fragment, now and then plain noise
	task send_fragment();
		int e;
		int n;
		logic [7:0] b;
		string ops;
		string blanks;
		ops = "=<>+-*/,;().!";
		blanks = " \t\r\n";
		case ($urandom_range(0, 11))
			0, 1: begin
				e = $urandom_range(0, sts_pkg::KW_COUNT - 1);
				for (int i = 0; i < int'(sts_pkg::KW_LEN[e]); i++) begin
					b = sts_pkg::KW_TEXT[e][8 * (int'(sts_pkg::KW_LEN[e]) - 1 - i) +: 8];
					send(1'b0, $urandom_range(0, 1) ? b | 8'h20 : b);
				end
			end
			2: begin
				n = $urandom_range(1, 11);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 3))
						0: send(1'b0, "_");
						1: send(1'b0, i == 0 ? "z" : 8'("0" + $urandom_range(0, 9)));
						2: send(1'b0, 8'("a" + $urandom_range(0, 25)));
						default: send(1'b0, 8'("A" + $urandom_range(0, 25)));
					endcase
			end
			3: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) send(1'b0, 8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					send(1'b0, ".");
					n = $urandom_range(0, 2);
					for (int i = 0; i < n; i++) send(1'b0, 8'("0" + $urandom_range(0, 9)));
				end
			end
			4: begin
				send(1'b0, "'");
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 4))
						0: send_text("''");
						1: send_text("\\'");
						2: send(1'b0, "\\");
						3: send(1'b0, 8'h0A);
						default: send(1'b0, 8'($urandom_range(0, 255)));
					endcase
				if ($urandom_range(0, 5) != 0) send(1'b0, "'");
			end
			5, 6: begin
				case ($urandom_range(0, 7))
					0: send_text("<>");
					1: send_text("!=");
					2: send_text("<=");
					3: send_text(">=");
					default: send(1'b0, ops[$urandom_range(0, ops.len() - 1)]);
				endcase
			end
			7: begin
				send_text("--");
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) send(1'b0, 8'($urandom_range(0, 255)));
				send(1'b0, 8'h0A);
			end
			8, 9: send(1'b0, blanks[$urandom_range(0, blanks.len() - 1)]);
			10: send(1'b0, 8'($urandom_range(0, 255)));
			default: if ($urandom_range(0, 3) == 0) send_end();
			else send(1'b0, " ");
		endcase
	endtask

	initial begin
		int guard;
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.cmd <= 1'b0;
		text_ch.char_in <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: keywords, operators, floats, escapes, lone bang, odd bytes
		send_text("SeLeCt x1<>2.5!=1.;!");
		send_end();
		send_text("'a''\\'b'--c\n");
		send(1'b0, 8'h00);
		send(1'b0, 8'hFF);
		send_text("7.");
		send_end();
		send_text("'open");
		send_end();

		// Random fragments
		for (int k = 0; k < 80; k++) send_fragment();
		send_end();
		text_ch.valid <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
